/* rtl/pow2_first_fit_heap_allocator_unit_defines.svh */
// ----------------------------------------------------------------------------
// pow2 first-fit heap allocator assertion macros
// shared check templates, sampled on clk with reset held off
// ----------------------------------------------------------------------------
`ifndef POW2_FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define POW2_FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// property must hold at every sampled edge
`define PFFA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen
`define PFFA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/pffa_pkg.sv */
// ----------------------------------------------------------------------------
// pffa_pkg
// sizes, codes and block table interface types of the heap allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pffa_pkg;

  localparam int HEAP_BYTES       = 4096;
  localparam int MAX_BLOCKS       = 64;
  localparam int MAX_ACCESS_BYTES = 8;

  localparam int ADDR_W = 12;
  localparam int SIZE_W = 13;
  localparam int CNT_W  = 7;
  localparam int EXT_W  = 13;
  localparam int SPAN_W = 14;

  typedef enum logic [1:0] {
    OP_CALL  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_ADDR    = 3'd1,
    ST_VIOLATION   = 3'd2,
    ST_BAD_REALLOC = 3'd3,
    ST_BAD_FREE    = 3'd4,
    ST_NO_MEMORY   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    TC_HOLD   = 2'd0,
    TC_INSERT = 2'd1,
    TC_REMOVE = 2'd2,
    TC_RESIZE = 2'd3
  } tcmd_op_t;

  typedef struct packed {
    logic [ADDR_W-1:0] off;
    logic [SIZE_W-1:0] len;
  } blk_t;

  typedef struct packed {
    tcmd_op_t          op;
    logic [ADDR_W-1:0] key;
    logic [SIZE_W-1:0] len;
  } tbl_cmd_t;

  typedef struct packed {
    logic [SPAN_W-1:0] q_pos;
    logic [SPAN_W-1:0] q_end;
    logic              skip_en;
    logic [ADDR_W-1:0] skip_off;
    logic [ADDR_W-1:0] a_addr;
    logic [SPAN_W-1:0] a_end;
  } tbl_qry_t;

  typedef struct packed {
    logic              overlap;
    logic              match;
    logic [SIZE_W-1:0] match_len;
    logic              contain;
  } tbl_rsp_t;

endpackage

`default_nettype wire

/* rtl/pffa_cell.sv */
// ----------------------------------------------------------------------------
// pffa_cell
// one slot of the sorted block table, shifts with its neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module pffa_cell (
  input  wire logic               clk,
  input  wire logic               valid,
  input  wire logic               is_tail,
  input  wire logic               left_valid,
  input  wire pffa_pkg::blk_t     left_blk,
  input  wire pffa_pkg::blk_t     right_blk,
  input  wire pffa_pkg::tbl_cmd_t cmd,
  input  wire pffa_pkg::tbl_qry_t qry,
  output pffa_pkg::blk_t          blk,
  output pffa_pkg::tbl_rsp_t      rsp
);

  pffa_pkg::blk_t blk_r;
  pffa_pkg::blk_t blk_nxt;
  pffa_pkg::blk_t new_blk;
  logic [pffa_pkg::SPAN_W-1:0] blk_end;
  logic ge_self;
  logic ge_left;
  logic skip_me;

  assign blk_end = pffa_pkg::SPAN_W'(blk_r.off) + pffa_pkg::SPAN_W'(blk_r.len);
  assign ge_self = valid && (blk_r.off >= cmd.key);
  assign ge_left = left_valid && (left_blk.off >= cmd.key);
  assign new_blk = '{off: cmd.key, len: cmd.len};

  always_comb begin
    blk_nxt = blk_r;
    unique case (cmd.op)
      pffa_pkg::TC_INSERT: begin
        // entries at or above the key move one slot up
        if (ge_self) begin
          blk_nxt = ge_left ? left_blk : new_blk;
        end else if (is_tail) begin
          blk_nxt = ge_left ? left_blk : new_blk;
        end
      end
      pffa_pkg::TC_REMOVE: begin
        if (ge_self) begin
          blk_nxt = right_blk;
        end
      end
      pffa_pkg::TC_RESIZE: begin
        if (valid && blk_r.off == cmd.key) begin
          blk_nxt.len = cmd.len;
        end
      end
      default: begin
        blk_nxt = blk_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

  assign skip_me = qry.skip_en && (blk_r.off == qry.skip_off);

  always_comb begin
    rsp.overlap   = valid && !skip_me &&
                    (pffa_pkg::SPAN_W'(blk_r.off) < qry.q_end) && (blk_end > qry.q_pos);
    rsp.match     = valid && (blk_r.off == qry.a_addr);
    rsp.match_len = rsp.match ? blk_r.len : '0;
    rsp.contain   = valid && (blk_r.off <= qry.a_addr) && (qry.a_end <= blk_end);
  end

  assign blk = blk_r;

endmodule

`default_nettype wire

/* rtl/pffa_table.sv */
// ----------------------------------------------------------------------------
// pffa_table
// row of block cells sorted by offset, with merged query answers
// ----------------------------------------------------------------------------
`default_nettype none

module pffa_table (
  input  wire logic                       clk,
  input  wire logic [pffa_pkg::CNT_W-1:0] count,
  input  wire pffa_pkg::tbl_cmd_t         cmd,
  input  wire pffa_pkg::tbl_qry_t         qry,
  output pffa_pkg::tbl_rsp_t              rsp
);

  pffa_pkg::blk_t     blk_w [pffa_pkg::MAX_BLOCKS];
  pffa_pkg::tbl_rsp_t rsp_w [pffa_pkg::MAX_BLOCKS];
  logic               vld_w [pffa_pkg::MAX_BLOCKS];

  for (genvar g = 0; g < pffa_pkg::MAX_BLOCKS; g++) begin : g_cell
    pffa_pkg::blk_t left_b;
    pffa_pkg::blk_t right_b;
    logic           left_v;

    assign vld_w[g] = count > pffa_pkg::CNT_W'(g);

    if (g == 0) begin : g_first
      assign left_b = '0;
      assign left_v = 1'b0;
    end else begin : g_mid
      assign left_b = blk_w[g-1];
      assign left_v = vld_w[g-1];
    end

    if (g == pffa_pkg::MAX_BLOCKS - 1) begin : g_last
      assign right_b = '0;
    end else begin : g_inner
      assign right_b = blk_w[g+1];
    end

    pffa_cell u_cell (
      .clk        (clk),
      .valid      (vld_w[g]),
      .is_tail    (count == pffa_pkg::CNT_W'(g)),
      .left_valid (left_v),
      .left_blk   (left_b),
      .right_blk  (right_b),
      .cmd        (cmd),
      .qry        (qry),
      .blk        (blk_w[g]),
      .rsp        (rsp_w[g])
    );
  end

  // blocks are disjoint, so at most one cell answers a match or contain
  always_comb begin
    rsp = '0;
    for (int k = 0; k < pffa_pkg::MAX_BLOCKS; k++) begin
      rsp.overlap   = rsp.overlap | rsp_w[k].overlap;
      rsp.match     = rsp.match | rsp_w[k].match;
      rsp.match_len = rsp.match_len | rsp_w[k].match_len;
      rsp.contain   = rsp.contain | rsp_w[k].contain;
    end
  end

endmodule

`default_nettype wire

/* rtl/pow2_first_fit_heap_allocator_unit.sv */
// ----------------------------------------------------------------------------
// pow2_first_fit_heap_allocator_unit
// power-of-two first-fit heap with a sorted block table and checked access
// ----------------------------------------------------------------------------
//  channel   ports                                      handshake
//  input     in_operation in_address in_size            start & !busy
//            in_write_data
//  result    out_status out_result_address              out_valid, one cycle
//            out_read_data
//
//  busy covers the decide state; a new block adds the first-fit walk over
//  candidate offsets and the insert, a growth adds the in-place check first,
//  a relocation the walk, a read and a write per byte moved
//  (one byte port on the heap memory) and the insert; a read adds
//  an issue and a capture per byte, a write a store; the result shows the next cycle
//  synchronous reset empties the table and the heap extent at once
//  the result strobe is never stalled; busy falls as it is shown
// ----------------------------------------------------------------------------
`default_nettype none

`include "pow2_first_fit_heap_allocator_unit_defines.svh"

module pow2_first_fit_heap_allocator_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  in_operation,
  input  wire logic [pffa_pkg::ADDR_W-1:0] in_address,
  input  wire logic [pffa_pkg::SIZE_W-1:0] in_size,
  input  wire logic [63:0]                 in_write_data,
  output logic                             out_valid,
  output logic [2:0]                       out_status,
  output logic [pffa_pkg::ADDR_W-1:0]      out_result_address,
  output logic [63:0]                      out_read_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_GROW, S_SCAN, S_COPY_RD, S_COPY_WR, S_INSERT,
    S_RD_ISSUE, S_RD_CAP, S_WR
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]                  op_r, op_nxt;
  logic [pffa_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [pffa_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [63:0]                 wdata_r, wdata_nxt;
  logic [pffa_pkg::EXT_W-1:0]  pos_r, pos_nxt;
  logic [pffa_pkg::SIZE_W-1:0] mlen_r, mlen_nxt;
  logic                        move_r, move_nxt;
  logic [pffa_pkg::SIZE_W-1:0] idx_r, idx_nxt;
  logic [63:0]                 rd_r, rd_nxt;
  logic [pffa_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [pffa_pkg::EXT_W-1:0]  ext_r, ext_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [2:0]                  out_status_r, out_status_nxt;
  logic [pffa_pkg::ADDR_W-1:0] out_res_r, out_res_nxt;
  logic [63:0]                 out_rd_r, out_rd_nxt;

  logic                        fin;
  pffa_pkg::status_t           fin_st;
  logic [pffa_pkg::ADDR_W-1:0] fin_res;

  logic [pffa_pkg::SPAN_W-1:0] bs;
  logic [pffa_pkg::SPAN_W-1:0] pos_end;
  logic [pffa_pkg::SPAN_W-1:0] addr_end;
  logic [pffa_pkg::SIZE_W-1:0] copy_j;

  pffa_pkg::tbl_cmd_t cmd;
  pffa_pkg::tbl_qry_t qry;
  pffa_pkg::tbl_rsp_t rsp;

  logic [7:0]                  heap_mem [pffa_pkg::HEAP_BYTES];
  logic                        mem_we;
  logic [pffa_pkg::ADDR_W-1:0] mem_wa;
  logic [pffa_pkg::ADDR_W-1:0] mem_ra;
  logic [7:0]                  mem_wd;
  logic [7:0]                  mem_q;

  function automatic logic [pffa_pkg::SPAN_W-1:0] pow2_ceil(
    input logic [pffa_pkg::SIZE_W-1:0] s
  );
    logic [pffa_pkg::SPAN_W-1:0] r;
    r = '0;
    for (int i = pffa_pkg::SPAN_W - 1; i >= 0; i--) begin
      if ((pffa_pkg::SPAN_W'(1) << i) >= pffa_pkg::SPAN_W'(s)) begin
        r = pffa_pkg::SPAN_W'(1) << i;
      end
    end
    return r;
  endfunction

  assign bs       = pow2_ceil(size_r);
  assign pos_end  = pffa_pkg::SPAN_W'(pos_r) + bs;
  assign addr_end = pffa_pkg::SPAN_W'(addr_r) + bs;
  // copy backwards when the new place lies above the old one
  assign copy_j   = (pffa_pkg::SIZE_W'(pos_r) > pffa_pkg::SIZE_W'(addr_r)) ?
                    (mlen_r - pffa_pkg::SIZE_W'(1) - idx_r) : idx_r;

  always_comb begin
    qry          = '0;
    qry.a_addr   = addr_r;
    qry.a_end    = pffa_pkg::SPAN_W'(addr_r) + pffa_pkg::SPAN_W'(size_r);
    qry.skip_off = addr_r;
    if (state_r == S_GROW) begin
      qry.q_pos   = pffa_pkg::SPAN_W'(addr_r) + pffa_pkg::SPAN_W'(mlen_r);
      qry.q_end   = addr_end;
      qry.skip_en = 1'b1;
    end else begin
      qry.q_pos   = pffa_pkg::SPAN_W'(pos_r);
      qry.q_end   = pos_end;
      qry.skip_en = move_r;
    end
  end

  pffa_table u_table (
    .clk   (clk),
    .count (count_r),
    .cmd   (cmd),
    .qry   (qry),
    .rsp   (rsp)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    size_nxt       = size_r;
    wdata_nxt      = wdata_r;
    pos_nxt        = pos_r;
    mlen_nxt       = mlen_r;
    move_nxt       = move_r;
    idx_nxt        = idx_r;
    rd_nxt         = rd_r;
    count_nxt      = count_r;
    ext_nxt        = ext_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_res_nxt    = out_res_r;
    out_rd_nxt     = out_rd_r;
    fin            = 1'b0;
    fin_st         = pffa_pkg::ST_OK;
    fin_res        = '0;
    cmd            = '{op: pffa_pkg::TC_HOLD, key: addr_r, len: '0};
    mem_we         = 1'b0;
    mem_wa         = addr_r + pffa_pkg::ADDR_W'(idx_r);
    mem_ra         = addr_r + pffa_pkg::ADDR_W'(idx_r);
    mem_wd         = wdata_r[{idx_r[2:0], 3'b000} +: 8];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_operation;
          addr_nxt  = in_address;
          size_nxt  = in_size;
          wdata_nxt = in_write_data;
          move_nxt  = 1'b0;
          idx_nxt   = '0;
          rd_nxt    = '0;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (op_r)
          pffa_pkg::OP_CALL: begin
            if (size_r == '0) begin
              if (addr_r == '0) begin
                fin = 1'b1;
              end else if (rsp.match) begin
                cmd.op    = pffa_pkg::TC_REMOVE;
                count_nxt = count_r - pffa_pkg::CNT_W'(1);
                fin       = 1'b1;
              end else begin
                fin    = 1'b1;
                fin_st = pffa_pkg::ST_BAD_FREE;
              end
            end else if (addr_r == '0) begin
              if (bs > pffa_pkg::SPAN_W'(pffa_pkg::HEAP_BYTES) ||
                  count_r >= pffa_pkg::CNT_W'(pffa_pkg::MAX_BLOCKS)) begin
                fin    = 1'b1;
                fin_st = pffa_pkg::ST_NO_MEMORY;
              end else begin
                pos_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end else if (!rsp.match) begin
              fin    = 1'b1;
              fin_st = pffa_pkg::ST_BAD_REALLOC;
            end else if (bs > pffa_pkg::SPAN_W'(pffa_pkg::HEAP_BYTES)) begin
              fin    = 1'b1;
              fin_st = pffa_pkg::ST_NO_MEMORY;
            end else if (bs <= pffa_pkg::SPAN_W'(rsp.match_len)) begin
              // shrink or same size: stays in place
              cmd.op  = pffa_pkg::TC_RESIZE;
              cmd.len = pffa_pkg::SIZE_W'(bs);
              if (addr_end > pffa_pkg::SPAN_W'(ext_r)) begin
                ext_nxt = pffa_pkg::EXT_W'(addr_end);
              end
              fin     = 1'b1;
              fin_res = addr_r;
            end else begin
              mlen_nxt  = rsp.match_len;
              state_nxt = S_GROW;
            end
          end
          pffa_pkg::OP_READ, pffa_pkg::OP_WRITE: begin
            if (size_r == '0 ||
                size_r > pffa_pkg::SIZE_W'(pffa_pkg::MAX_ACCESS_BYTES) ||
                qry.a_end > pffa_pkg::SPAN_W'(ext_r)) begin
              fin    = 1'b1;
              fin_st = pffa_pkg::ST_BAD_ADDR;
            end else if (!rsp.contain) begin
              fin    = 1'b1;
              fin_st = pffa_pkg::ST_VIOLATION;
            end else begin
              idx_nxt   = '0;
              state_nxt = (op_r == pffa_pkg::OP_READ) ? S_RD_ISSUE : S_WR;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_GROW: begin
        if (addr_end <= pffa_pkg::SPAN_W'(pffa_pkg::HEAP_BYTES) && !rsp.overlap) begin
          cmd.op  = pffa_pkg::TC_RESIZE;
          cmd.len = pffa_pkg::SIZE_W'(bs);
          if (addr_end > pffa_pkg::SPAN_W'(ext_r)) begin
            ext_nxt = pffa_pkg::EXT_W'(addr_end);
          end
          fin     = 1'b1;
          fin_res = addr_r;
        end else begin
          move_nxt  = 1'b1;
          pos_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pos_r < ext_r && rsp.overlap) begin
          pos_nxt = pffa_pkg::EXT_W'(pos_end);
        end else if (pos_end > pffa_pkg::SPAN_W'(pffa_pkg::HEAP_BYTES)) begin
          fin    = 1'b1;
          fin_st = pffa_pkg::ST_NO_MEMORY;
        end else if (!move_r) begin
          state_nxt = S_INSERT;
        end else begin
          cmd.op    = pffa_pkg::TC_REMOVE;
          count_nxt = count_r - pffa_pkg::CNT_W'(1);
          idx_nxt   = '0;
          state_nxt = S_COPY_RD;
        end
      end
      S_COPY_RD: begin
        mem_ra    = addr_r + pffa_pkg::ADDR_W'(copy_j);
        state_nxt = S_COPY_WR;
      end
      S_COPY_WR: begin
        mem_we = 1'b1;
        mem_wa = pffa_pkg::ADDR_W'(pos_r) + pffa_pkg::ADDR_W'(copy_j);
        mem_wd = mem_q;
        if (idx_r == mlen_r - pffa_pkg::SIZE_W'(1)) begin
          state_nxt = S_INSERT;
        end else begin
          idx_nxt   = idx_r + pffa_pkg::SIZE_W'(1);
          state_nxt = S_COPY_RD;
        end
      end
      S_INSERT: begin
        cmd.op    = pffa_pkg::TC_INSERT;
        cmd.key   = pffa_pkg::ADDR_W'(pos_r);
        cmd.len   = pffa_pkg::SIZE_W'(bs);
        count_nxt = count_r + pffa_pkg::CNT_W'(1);
        if (pos_end > pffa_pkg::SPAN_W'(ext_r)) begin
          ext_nxt = pffa_pkg::EXT_W'(pos_end);
        end
        fin     = 1'b1;
        fin_res = pffa_pkg::ADDR_W'(pos_r);
      end
      S_RD_ISSUE: begin
        state_nxt = S_RD_CAP;
      end
      S_RD_CAP: begin
        rd_nxt[{idx_r[2:0], 3'b000} +: 8] = mem_q;
        if (idx_r == size_r - pffa_pkg::SIZE_W'(1)) begin
          fin = 1'b1;
        end else begin
          idx_nxt   = idx_r + pffa_pkg::SIZE_W'(1);
          state_nxt = S_RD_ISSUE;
        end
      end
      S_WR: begin
        mem_we = 1'b1;
        if (idx_r == size_r - pffa_pkg::SIZE_W'(1)) begin
          fin = 1'b1;
        end else begin
          idx_nxt = idx_r + pffa_pkg::SIZE_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = fin_st;
      out_res_nxt    = fin_res;
      out_rd_nxt     = (state_r == S_RD_CAP) ? rd_nxt : '0;
      state_nxt      = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ext_r       <= '0;
      out_valid_r <= 1'b0;
      move_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ext_r       <= ext_nxt;
      out_valid_r <= out_valid_nxt;
      move_r      <= move_nxt;
    end
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    size_r       <= size_nxt;
    wdata_r      <= wdata_nxt;
    pos_r        <= pos_nxt;
    mlen_r       <= mlen_nxt;
    idx_r        <= idx_nxt;
    rd_r         <= rd_nxt;
    out_status_r <= out_status_nxt;
    out_res_r    <= out_res_nxt;
    out_rd_r     <= out_rd_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_wa] <= mem_wd;
    end
    mem_q <= heap_mem[mem_ra];
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_res_r;
  assign out_read_data      = out_rd_r;

  `PFFA_CHECK(a_single_strobe, out_valid |=> !out_valid, "result strobe held two cycles")
  `PFFA_CHECK(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
  `PFFA_NEVER(a_count_max, count_r > pffa_pkg::CNT_W'(pffa_pkg::MAX_BLOCKS), "block count overflow")
  `PFFA_NEVER(a_extent_max, ext_r > pffa_pkg::EXT_W'(pffa_pkg::HEAP_BYTES), "heap extent overflow")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the power-of-two first-fit heap allocator: a short
// directed table, then random call/read/write/reserved items checked against an
// in-bench model of the block table, extent and heap bytes
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM  = 1425;
  localparam int CYC_LIMIT = 100_000_000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [1:0]                    in_operation = '0;
  logic [pffa_pkg::ADDR_W-1:0]   in_address = '0;
  logic [pffa_pkg::SIZE_W-1:0]   in_size = '0;
  logic [63:0]                   in_write_data = '0;
  logic                          out_valid;
  logic [2:0]                    out_status;
  logic [pffa_pkg::ADDR_W-1:0]   out_result_address;
  logic [63:0]                   out_read_data;

  pow2_first_fit_heap_allocator_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_address(in_address), .in_size(in_size),
    .in_write_data(in_write_data), .out_valid(out_valid), .out_status(out_status),
    .out_result_address(out_result_address), .out_read_data(out_read_data)
  );

  always #10 clk = ~clk;

  typedef struct {
    pffa_pkg::status_t           st;
    logic [pffa_pkg::ADDR_W-1:0] addr;
    logic [63:0]                 rdata;
  } answer_t;

  typedef struct {
    pffa_pkg::op_t     op;
    int                addr;
    int                size;
    logic [63:0]       wd;
    bit                typed;
    pffa_pkg::status_t st;
    int                ra;
    logic [63:0]       rd;
  } dir_row_t;

  answer_t answer_q[$];
  int      n_errors = 0;
  int      n_checked = 0;
  int      n_accepted = 0;
  int      n_oom = 0;
  int      n_moves = 0;
  longint  cycles = 0;

  // heap model state
  int       blk_off[pffa_pkg::MAX_BLOCKS];
  int       blk_len[pffa_pkg::MAX_BLOCKS];
  int       blk_cnt;
  int       extent;
  bit [7:0] mem[pffa_pkg::HEAP_BYTES];
  bit       mem_set[pffa_pkg::HEAP_BYTES];

  function automatic int first_end_after(int pos, int skip);
    for (int k = 0; k < blk_cnt; k++)
      if (k != skip && blk_off[k] + blk_len[k] > pos) return k;
    return blk_cnt;
  endfunction

  function automatic bit span_free(int pos, int len, int skip);
    int k;
    k = first_end_after(pos, skip);
    return k >= blk_cnt || pos + len <= blk_off[k];
  endfunction

  // first-fit walk over multiples of bs; -1 when nothing fits
  function automatic int fit_slot(int bs, int skip);
    int pos;
    pos = 0;
    while (pos < extent) begin
      if (span_free(pos, bs, skip)) break;
      pos += bs;
    end
    return (pos + bs > pffa_pkg::HEAP_BYTES) ? -1 : pos;
  endfunction

  function automatic int block_index(int pos);
    for (int k = 0; k < blk_cnt; k++)
      if (blk_off[k] == pos) return k;
    return blk_cnt;
  endfunction

  function automatic void drop_block(int k);
    for (int j = k; j + 1 < blk_cnt; j++) begin
      blk_off[j] = blk_off[j+1];
      blk_len[j] = blk_len[j+1];
    end
    blk_cnt--;
  endfunction

  function automatic void add_block(int pos, int len);
    int k;
    k = blk_cnt;
    while (k > 0 && blk_off[k-1] >= pos) begin
      blk_off[k] = blk_off[k-1];
      blk_len[k] = blk_len[k-1];
      k--;
    end
    blk_off[k] = pos;
    blk_len[k] = len;
    blk_cnt++;
    if (pos + len > extent) extent = pos + len;
  endfunction

  function automatic pffa_pkg::status_t access_status(int a, int n);
    int k;
    if (n == 0 || n > pffa_pkg::MAX_ACCESS_BYTES || a + n > extent)
      return pffa_pkg::ST_BAD_ADDR;
    k = first_end_after(a, blk_cnt);
    if (k >= blk_cnt || blk_off[k] > a || a + n > blk_off[k] + blk_len[k])
      return pffa_pkg::ST_VIOLATION;
    return pffa_pkg::ST_OK;
  endfunction

  function automatic pffa_pkg::status_t heap_call(int a, int n, output int ra);
    int bs, k, pos, old_len;
    bit [7:0] tmp_b[pffa_pkg::HEAP_BYTES];
    bit       tmp_s[pffa_pkg::HEAP_BYTES];
    ra = 0;
    if (n == 0) begin
      if (a == 0) return pffa_pkg::ST_OK;
      k = block_index(a);
      if (k >= blk_cnt) return pffa_pkg::ST_BAD_FREE;
      drop_block(k);
      return pffa_pkg::ST_OK;
    end
    bs = 1;
    while (bs < n) bs <<= 1;
    if (a == 0) begin
      if (bs > pffa_pkg::HEAP_BYTES || blk_cnt >= pffa_pkg::MAX_BLOCKS)
        return pffa_pkg::ST_NO_MEMORY;
      pos = fit_slot(bs, blk_cnt);
      if (pos < 0) return pffa_pkg::ST_NO_MEMORY;
      add_block(pos, bs);
      ra = pos;
      return pffa_pkg::ST_OK;
    end
    k = block_index(a);
    if (k >= blk_cnt) return pffa_pkg::ST_BAD_REALLOC;
    if (bs > pffa_pkg::HEAP_BYTES) return pffa_pkg::ST_NO_MEMORY;
    if (bs <= blk_len[k] ||
        (a + bs <= pffa_pkg::HEAP_BYTES &&
         span_free(a + blk_len[k], bs - blk_len[k], k))) begin
      blk_len[k] = bs;
      if (a + bs > extent) extent = a + bs;
      ra = a;
      return pffa_pkg::ST_OK;
    end
    pos = fit_slot(bs, k);
    if (pos < 0) return pffa_pkg::ST_NO_MEMORY;
    old_len = blk_len[k];
    drop_block(k);
    // copy through a buffer so overlapping moves behave like memmove
    for (int i = 0; i < old_len; i++) begin
      tmp_b[i] = mem[a+i];
      tmp_s[i] = mem_set[a+i];
    end
    for (int i = 0; i < old_len; i++) begin
      mem[pos+i] = tmp_b[i];
      mem_set[pos+i] = tmp_s[i];
    end
    for (int i = old_len; i < bs; i++) mem_set[pos+i] = 1'b0;
    add_block(pos, bs);
    n_moves++;
    ra = pos;
    return pffa_pkg::ST_OK;
  endfunction

  function automatic answer_t heap_step(pffa_pkg::op_t op, int a, int n, logic [63:0] wd);
    answer_t r;
    int ra;
    r.st = pffa_pkg::ST_OK;
    r.addr = '0;
    r.rdata = '0;
    if (op == pffa_pkg::OP_CALL) begin
      r.st = heap_call(a, n, ra);
      r.addr = ra[pffa_pkg::ADDR_W-1:0];
      if (r.st == pffa_pkg::ST_NO_MEMORY) n_oom++;
    end else if (op == pffa_pkg::OP_READ || op == pffa_pkg::OP_WRITE) begin
      r.st = access_status(a, n);
      if (r.st == pffa_pkg::ST_OK)
        for (int i = 0; i < n; i++)
          if (op == pffa_pkg::OP_WRITE) begin
            mem[a+i] = wd[8*i +: 8];
            mem_set[a+i] = 1'b1;
          end else
            r.rdata[8*i +: 8] = mem[a+i];
    end
    return r;
  endfunction

  // a successful read of never-written bytes is outside the contract
  function automatic bit read_touches_unset(int a, int n);
    if (access_status(a, n) != pffa_pkg::ST_OK) return 1'b0;
    for (int i = 0; i < n; i++)
      if (!mem_set[a+i]) return 1'b1;
    return 1'b0;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    n_errors++;
    if (n_errors <= 20)
      $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_checked);
  endtask

  // result checker; the receiver cannot stall, so every strobe is taken
  always @(posedge clk) begin
    answer_t w;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0)
        report("unexpected result", {61'd0, out_status}, 64'd0);
      else begin
        w = answer_q.pop_front();
        if (out_status !== w.st) report("status", {61'd0, out_status}, {61'd0, w.st});
        if (out_result_address !== w.addr)
          report("result_address", {52'd0, out_result_address}, {52'd0, w.addr});
        if (out_read_data !== w.rdata) report("read_data", out_read_data, w.rdata);
      end
      n_checked++;
    end
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // drive one item, wait for it to be taken, then predict its answer
  task automatic send_item(pffa_pkg::op_t op, int a, int n, logic [63:0] wd, int idle_pct,
                           bit typed, answer_t typed_ans);
    answer_t p;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start         <= 1'b1;
    in_operation  <= op;
    in_address    <= a[pffa_pkg::ADDR_W-1:0];
    in_size       <= n[pffa_pkg::SIZE_W-1:0];
    in_write_data <= wd;
    do @(posedge clk); while (busy);
    p = heap_step(op, a, n, wd);
    answer_q.push_back(typed ? typed_ans : p);
    n_accepted++;
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 32);
    if (r < 97) return $urandom_range(1, 256);
    return $urandom_range(1, pffa_pkg::HEAP_BYTES);
  endfunction

  dir_row_t dir_tab[24] = '{
    '{pffa_pkg::OP_READ,  0,    1,    64'd0, 1, pffa_pkg::ST_BAD_ADDR,    0, 64'd0},
    '{pffa_pkg::OP_CALL,  0,    0,    64'd0, 1, pffa_pkg::ST_OK,          0, 64'd0},
    '{pffa_pkg::OP_CALL,  5,    0,    64'd0, 1, pffa_pkg::ST_BAD_FREE,    0, 64'd0},
    '{pffa_pkg::OP_CALL,  8,    4,    64'd0, 1, pffa_pkg::ST_BAD_REALLOC, 0, 64'd0},
    '{pffa_pkg::OP_CALL,  0,    4097, 64'd0, 1, pffa_pkg::ST_NO_MEMORY,   0, 64'd0},
    '{pffa_pkg::OP_CALL,  0,    1,    64'd0, 1, pffa_pkg::ST_OK,          0, 64'd0},
    '{pffa_pkg::OP_CALL,  0,    3,    64'd0, 0, pffa_pkg::ST_OK,          0, 64'd0},
    '{pffa_pkg::OP_WRITE, 0,    1,    '1,    0, pffa_pkg::ST_OK,          0, 64'd0},
    '{pffa_pkg::OP_WRITE, 4,    4,    64'h0123_4567_89ab_cdef, 0, pffa_pkg::ST_OK, 0, 64'd0},
    '{pffa_pkg::OP_READ,  4,    4,    64'd0, 0, pffa_pkg::ST_OK,          0, 64'd0},
    '{pffa_pkg::OP_READ,  4,    0,    64'd0, 1, pffa_pkg::ST_BAD_ADDR,    0, 64'd0},
    '{pffa_pkg::OP_READ,  4,    9,    64'd0, 1, pffa_pkg::ST_BAD_ADDR,    0, 64'd0},
    '{pffa_pkg::OP_READ,  1,    1,    64'd0, 1, pffa_pkg::ST_VIOLATION,   0, 64'd0},
    '{pffa_pkg::OP_CALL,  4,    16,   64'd0, 0, pffa_pkg::ST_OK,          0, 64'd0},
    '{pffa_pkg::OP_CALL,  4,    2,    64'd0, 0, pffa_pkg::ST_OK,          0, 64'd0},
    '{pffa_pkg::OP_RSVD,  4095, 8191, '1,    1, pffa_pkg::ST_OK,          0, 64'd0},
    '{pffa_pkg::OP_CALL,  0,    4096, 64'd0, 1, pffa_pkg::ST_NO_MEMORY,   0, 64'd0},
    '{pffa_pkg::OP_CALL,  4,    4096, 64'd0, 1, pffa_pkg::ST_NO_MEMORY,   0, 64'd0},
    '{pffa_pkg::OP_CALL,  4,    8,    64'd0, 0, pffa_pkg::ST_OK,          0, 64'd0},
    '{pffa_pkg::OP_CALL,  0,    8,    64'd0, 0, pffa_pkg::ST_OK,          0, 64'd0},
    '{pffa_pkg::OP_CALL,  4,    16,   64'd0, 0, pffa_pkg::ST_OK,          0, 64'd0},
    '{pffa_pkg::OP_READ,  32,   4,    64'd0, 0, pffa_pkg::ST_OK,          0, 64'd0},
    '{pffa_pkg::OP_CALL,  32,   0,    64'd0, 1, pffa_pkg::ST_OK,          0, 64'd0},
    '{pffa_pkg::OP_WRITE, 4095, 8,    '1,    1, pffa_pkg::ST_BAD_ADDR,    0, 64'd0}
  };

  initial begin
    answer_t ta;
    pffa_pkg::op_t op;
    int a, n, k, r, idle_pct;
    logic [63:0] wd;
    blk_cnt = 0;
    extent = 0;
    for (int i = 0; i < pffa_pkg::HEAP_BYTES; i++) mem_set[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      ta.st = dir_tab[i].st;
      ta.addr = dir_tab[i].ra[pffa_pkg::ADDR_W-1:0];
      ta.rdata = dir_tab[i].rd;
      send_item(dir_tab[i].op, dir_tab[i].addr, dir_tab[i].size, dir_tab[i].wd, 0,
                dir_tab[i].typed, ta);
    end

    for (int it = 0; it < N_RANDOM; it++) begin
      // idling phases: none, heavy, none, light
      case ((it * 4) / N_RANDOM)
        1:       idle_pct = 71;
        3:       idle_pct = 10;
        default: idle_pct = 0;
      endcase
      if (it == N_RANDOM / 2) begin
        start <= 1'b0;
        wait (answer_q.size() == 0);
        @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (blk_cnt == 0 && r < 90) r = 0;
      k = (blk_cnt > 0) ? $urandom_range(0, blk_cnt - 1) : 0;
      wd = {$urandom, $urandom};
      op = pffa_pkg::OP_CALL;
      a = 0;
      n = 0;
      if (r < 28) begin
        n = pick_size();
      end else if (r < 36) begin
        a = blk_off[k];
        n = pick_size();
      end else if (r < 46) begin
        a = blk_off[k];
      end else if (r < 90) begin
        op = (r < 68) ? pffa_pkg::OP_WRITE : pffa_pkg::OP_READ;
        a = blk_off[k] + $urandom_range(0, blk_len[k] - 1);
        n = $urandom_range(1, pffa_pkg::MAX_ACCESS_BYTES);
        if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 12);
      end else begin
        op = pffa_pkg::op_t'($urandom_range(0, 3));
        a = $urandom_range(0, pffa_pkg::HEAP_BYTES - 1);
        n = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 8191) : $urandom_range(0, 9);
      end
      if (a + n > pffa_pkg::HEAP_BYTES && op != pffa_pkg::OP_CALL &&
          op != pffa_pkg::OP_RSVD)
        ; // fails on the extent check, no heap byte is read
      else if (op == pffa_pkg::OP_READ && read_touches_unset(a, n))
        op = pffa_pkg::OP_WRITE;
      send_item(op, a, n, wd, idle_pct, 1'b0, ta);
    end
    start <= 1'b0;

    wait (answer_q.size() == 0);
    repeat (20) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d out-of-memory answers,",
             n_accepted, n_checked, n_oom);
    $display("%0d relocations, %0d blocks live, extent %0d", n_moves, blk_cnt, extent);
    if (n_errors == 0 && answer_q.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
